FILE: rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared widths, operation codes, sequencer states and unit control types of
// the MLFQ priority update engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlfq_pkg;

  // Field widths of the input and result words
  localparam int FUNC_W  = 3;
  localparam int TIDX_W  = 6;
  localparam int NICE_W  = 6;
  localparam int READY_W = 7;
  localparam int PRIO_W  = 6;
  localparam int RCPU_W  = 32;
  localparam int LOAD_W  = 32;
  localparam int LAVG_W  = 13;
  localparam int TBL_W   = RCPU_W + NICE_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DECAY = 3'd2;
  localparam logic [FUNC_W-1:0] FN_NICE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

  // Limits
  localparam int PRI_TOP   = 63;
  localparam int READY_MAX = 64;
  localparam logic signed [NICE_W-1:0] NICE_HI = 6'sd20;
  localparam logic signed [NICE_W-1:0] NICE_LO = -6'sd20;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_LATCH,
    ST_DISPATCH,
    ST_DIV,
    ST_MUL,
    ST_WRITE,
    ST_FMT_A,
    ST_FMT_B
  } mlfq_state_e;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_sts_t;

endpackage

`default_nettype wire

FILE: rtl/mlfq_priority_update_engine.sv
// ----------------------------------------------------------------------------
// mlfq_priority_update_engine
// Per word: capture, index wrap, table read and latch, dispatch, then the serial unit (divide
// then multiply for a non-idle decay, multiply for a load update), table write and formatting.
// One word in flight: the next word is taken only after its result is loaded for output,
// which index wrapping and a stalled older result both delay.
// Reset: load cleared at once; a clearing pass then zeroes the table, input stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlfq_priority_update_engine
  import mlfq_pkg::*;
#(
  parameter int THREAD_SLOTS  = 64,
  parameter int FRACTION_BITS = 14
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input word channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic        [FUNC_W-1:0]  func_i,
  input  wire logic        [TIDX_W-1:0]  thread_index_i,
  input  wire logic                      is_idle_i,
  input  wire logic signed [NICE_W-1:0]  nice_value_i,
  input  wire logic        [READY_W-1:0] ready_count_i,
  // result word channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic             [PRIO_W-1:0]  priority_res_o,
  output logic signed      [RCPU_W-1:0]  recent_cpu_x100_o,
  output logic             [LAVG_W-1:0]  load_avg_x100_o,
  output logic signed      [NICE_W-1:0]  nice_out_o
);

  localparam int IDX_W   = $clog2(THREAD_SLOTS);
  localparam int ACC_W   = 33 + FRACTION_BITS;
  localparam int SLOT_CW = $clog2(THREAD_SLOTS + 1);
  localparam int CMP_W   = (SLOT_CW > TIDX_W) ? SLOT_CW : TIDX_W;
  // 59/60 and 1/60 in fixed point, truncated
  localparam int C59     = (59 * (1 << FRACTION_BITS)) / 60;
  localparam int C1      = (1 << FRACTION_BITS) / 60;
  localparam logic [RCPU_W-1:0] ONE_FP = RCPU_W'(1) << FRACTION_BITS;

  mlfq_state_e state_q, state_d;

  // Clearing pass address
  logic [IDX_W-1:0] clr_q, clr_d;

  // Captured input word
  logic        [FUNC_W-1:0]  func_q;
  logic        [TIDX_W-1:0]  red_q;
  logic                      idle_q;
  logic signed [NICE_W-1:0]  nicein_q;
  logic        [READY_W-1:0] ready_q;
  logic                      red_ge;

  // Working copy of the addressed entry and the load average
  logic signed [RCPU_W-1:0]  recent_q;
  logic signed [NICE_W-1:0]  nice_q;
  logic        [LOAD_W-1:0]  load_q;

  // Result register
  logic                      out_valid_q;
  logic        [PRIO_W-1:0]  prio_q;
  logic signed [RCPU_W-1:0]  rcpu_q;
  logic        [LAVG_W-1:0]  lavg_q;
  logic signed [NICE_W-1:0]  nout_q;
  logic                      out_load;

  // Table port signals
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, addr;
  logic [TBL_W-1:0] mem_wdata, mem_rdata;

  // Shared unit
  mdu_ctl_t         mdu_ctl;
  mdu_sts_t         mdu_sts;
  logic [ACC_W-1:0] mdu_a, mdu_b, mdu_res;

  // Formatter
  logic                     fmt_cap;
  logic        [PRIO_W-1:0] fmt_prio;
  logic signed [RCPU_W-1:0] fmt_rcpu;
  logic        [LAVG_W-1:0] fmt_lavg;

  // Decay and load update results
  logic        [RCPU_W-1:0] rmag;
  logic        [RCPU_W-1:0] dec_mag;
  logic signed [RCPU_W-1:0] dec_val;
  logic        [LOAD_W-1:0] load_new;

  // Index wraps by repeated subtraction of the table depth
  assign red_ge = CMP_W'(red_q) >= CMP_W'(THREAD_SLOTS);
  assign addr   = IDX_W'(red_q);

  always_comb begin
    rmag     = recent_q[RCPU_W-1] ? RCPU_W'(-recent_q) : RCPU_W'(recent_q);
    // Product magnitude is floored, so negating gives truncation toward zero
    dec_mag  = RCPU_W'(mdu_res >> FRACTION_BITS);
    dec_val  = (recent_q[RCPU_W-1] ? -signed'(dec_mag) : signed'(dec_mag))
             + (RCPU_W'(nice_q) <<< FRACTION_BITS);
    load_new = LOAD_W'(mdu_res >> FRACTION_BITS) + (LOAD_W'(C1) * LOAD_W'(ready_q));
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == IDX_W'(THREAD_SLOTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MOD;
      end
      ST_MOD: begin
        if (!red_ge) state_d = ST_READ;
      end
      ST_READ:  state_d = ST_LATCH;
      ST_LATCH: state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (func_q == FN_LOAD) begin
          state_d = ST_MUL;
        end else if (func_q == FN_DECAY && !idle_q) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_DIV: begin
        if (mdu_sts.done) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mdu_sts.done) state_d = ST_WRITE;
      end
      ST_WRITE: state_d = ST_FMT_A;
      ST_FMT_A: state_d = ST_FMT_B;
      ST_FMT_B: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = addr;
    mem_wdata   = {nice_q, recent_q};
    mem_re      = 1'b0;
    mdu_ctl     = '{start: 1'b0, op: MDU_MUL};
    mdu_a       = ACC_W'(load_q);
    mdu_b       = ACC_W'(C59);
    fmt_cap     = 1'b0;
    out_load    = 1'b0;
    clr_d       = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        // zero one entry a cycle
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IDX_W'(1);
      end
      ST_READ: mem_re = 1'b1;
      ST_DISPATCH: begin
        if (func_q == FN_LOAD) begin
          // load * 59/60
          mdu_ctl = '{start: 1'b1, op: MDU_MUL};
        end else if (func_q == FN_DECAY && !idle_q) begin
          // coefficient 2L*F / (2L+F)
          mdu_ctl = '{start: 1'b1, op: MDU_DIV};
          mdu_a   = ACC_W'(load_q) << (FRACTION_BITS + 1);
          mdu_b   = (ACC_W'(load_q) << 1) + ACC_W'(ONE_FP);
        end
      end
      ST_DIV: begin
        // chain the coefficient straight into the multiply
        mdu_a = ACC_W'(rmag);
        mdu_b = mdu_res;
        if (mdu_sts.done) mdu_ctl = '{start: 1'b1, op: MDU_MUL};
      end
      ST_WRITE: mem_we = 1'b1;
      ST_FMT_A: fmt_cap = 1'b1;
      ST_FMT_B: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers and the load average
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      load_q      <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_MUL && mdu_sts.done && func_q == FN_LOAD) load_q <= load_new;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // capture the input word, saturating nice and ready count
    if (state_q == ST_IDLE && in_valid_i) begin
      func_q  <= func_i;
      red_q   <= thread_index_i;
      idle_q  <= is_idle_i;
      ready_q <= (ready_count_i > READY_W'(READY_MAX)) ? READY_W'(READY_MAX)
                                                       : ready_count_i;
      if (nice_value_i > NICE_HI) begin
        nicein_q <= NICE_HI;
      end else if (nice_value_i < NICE_LO) begin
        nicein_q <= NICE_LO;
      end else begin
        nicein_q <= nice_value_i;
      end
    end
    if (state_q == ST_MOD && red_ge) begin
      red_q <= TIDX_W'(CMP_W'(red_q) - CMP_W'(THREAD_SLOTS));
    end
    if (state_q == ST_LATCH) begin
      recent_q <= mem_rdata[RCPU_W-1:0];
      nice_q   <= mem_rdata[TBL_W-1:RCPU_W];
    end
    // idle thread keeps its tick and niceness
    if (state_q == ST_DISPATCH && !idle_q) begin
      if (func_q == FN_TICK) recent_q <= recent_q + ONE_FP;
      if (func_q == FN_NICE) nice_q   <= nicein_q;
    end
    if (state_q == ST_MUL && mdu_sts.done && func_q != FN_LOAD) recent_q <= dec_val;
    if (out_load) begin
      prio_q <= fmt_prio;
      rcpu_q <= fmt_rcpu;
      lavg_q <= fmt_lavg;
      nout_q <= nice_q;
    end
  end

  // --------------------------------------------------------------------------
  // Submodules
  // --------------------------------------------------------------------------
  mlfq_table #(
    .THREAD_SLOTS(THREAD_SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(addr),
    .rdata_o(mem_rdata)
  );

  mlfq_muldiv #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_muldiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mdu_ctl),
    .a_i   (mdu_a),
    .b_i   (mdu_b),
    .sts_o (mdu_sts),
    .res_o (mdu_res)
  );

  mlfq_fmt #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_fmt (
    .clk_i      (clk_i),
    .cap_i      (fmt_cap),
    .recent_i   (recent_q),
    .nice_i     (nice_q),
    .load_i     (load_q),
    .idle_i     (idle_q),
    .prio_o     (fmt_prio),
    .rcpu_x100_o(fmt_rcpu),
    .lavg_x100_o(fmt_lavg)
  );

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign priority_res_o    = prio_q;
  assign recent_cpu_x100_o = rcpu_q;
  assign load_avg_x100_o   = lavg_q;
  assign nice_out_o        = nout_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_mdu_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_ctl.start |-> !mdu_sts.busy)
    else $error("shared unit restarted while busy");

  a_mdu_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_sts.done |-> (state_q == ST_DIV || state_q == ST_MUL))
    else $error("shared unit finished outside a wait state");

  a_load_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MUL) |=> $stable(load_q))
    else $error("load average changed outside load update");

  a_out_from_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FMT_B)
    else $error("result word raised without formatting");

endmodule

`default_nettype wire

FILE: rtl/mlfq_muldiv.sv
// ----------------------------------------------------------------------------
// mlfq_muldiv
// Shared bit-serial unit: shift-add multiply or restoring divide, one bit of
// the FRACTION_BITS-wide multiplier or quotient per cycle on one adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlfq_muldiv
  import mlfq_pkg::*;
#(
  parameter  int FRACTION_BITS = 14,
  localparam int ACC_W         = 33 + FRACTION_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mdu_ctl_t         ctl_i,
  input  wire logic [ACC_W-1:0] a_i,
  input  wire logic [ACC_W-1:0] b_i,
  output mdu_sts_t              sts_o,
  output logic      [ACC_W-1:0] res_o
);

  localparam int CNT_W = $clog2(FRACTION_BITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(FRACTION_BITS - 1);

  logic [ACC_W-1:0] x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  mdu_op_e          op_q, op_d;
  logic [ACC_W-1:0] opa, opb;
  logic             cin;
  logic [ACC_W:0]   sum;

  // One adder: acc + x for multiply, x - y (carry = no borrow) for divide
  always_comb begin
    opa = (op_q == MDU_MUL) ? acc_q : x_q;
    opb = (op_q == MDU_MUL) ? x_q : ~y_q;
    cin = (op_q == MDU_DIV);
    sum = {1'b0, opa} + {1'b0, opb} + {{ACC_W{1'b0}}, cin};
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    op_d   = op_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      op_d  = ctl_i.op;
      acc_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
      x_d   = a_i;
      y_d   = (ctl_i.op == MDU_MUL) ? b_i : (b_i << (FRACTION_BITS - 1));
    end else if (run_q) begin
      y_d = y_q >> 1;
      if (op_q == MDU_MUL) begin
        if (y_q[0]) acc_d = sum[ACC_W-1:0];
        x_d = x_q << 1;
      end else begin
        acc_d = {acc_q[ACC_W-2:0], sum[ACC_W]};
        if (sum[ACC_W]) x_d = sum[ACC_W-1:0];
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= MDU_MUL;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign sts_o.busy = run_q;
  assign sts_o.done = done_q;
  assign res_o      = acc_q;

endmodule

`default_nettype wire

FILE: rtl/mlfq_table.sv
// ----------------------------------------------------------------------------
// mlfq_table
// Per-thread memory of recent CPU and niceness, one write and one registered
// read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlfq_table
  import mlfq_pkg::*;
#(
  parameter  int THREAD_SLOTS = 64,
  localparam int IDX_W        = $clog2(THREAD_SLOTS)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [TBL_W-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [TBL_W-1:0] rdata_o
);

  logic [TBL_W-1:0] mem_q [THREAD_SLOTS];
  logic [TBL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/mlfq_fmt.sv
// ----------------------------------------------------------------------------
// mlfq_fmt
// Result formatter: scales recent CPU and load by 100, forms the priority
// term, then rounds to nearest (ties away from zero) and clamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlfq_fmt
  import mlfq_pkg::*;
#(
  parameter int FRACTION_BITS = 14
) (
  input  wire logic                     clk_i,
  input  wire logic                     cap_i,
  input  wire logic signed [RCPU_W-1:0] recent_i,
  input  wire logic signed [NICE_W-1:0] nice_i,
  input  wire logic        [LOAD_W-1:0] load_i,
  input  wire logic                     idle_i,
  output logic             [PRIO_W-1:0] prio_o,
  output logic signed      [RCPU_W-1:0] rcpu_x100_o,
  output logic             [LAVG_W-1:0] lavg_x100_o
);

  localparam int RX_W = RCPU_W + 7;
  localparam int PX_W = ((FRACTION_BITS + 7 > 30) ? FRACTION_BITS + 7 : 30) + 2;
  localparam logic [RX_W:0]   HALF_R = (RX_W + 1)'(1) << (FRACTION_BITS - 1);
  localparam logic [PX_W-1:0] HALF_P = PX_W'(1) << (FRACTION_BITS - 1);

  logic                   rneg;
  logic [RCPU_W-1:0]      rmag;
  logic [RX_W-1:0]        rx100, lx100;
  logic signed [PX_W-1:0] top_c, nice_c, q4_c, px;

  logic                   rneg_q, idle_q;
  logic [RX_W-1:0]        rx_q, lx_q;
  logic signed [PX_W-1:0] px_q;

  logic [RX_W:0]          rr, lr;
  logic [PX_W-1:0]        pu;

  // Capture stage: magnitudes times 100 and the unrounded priority
  always_comb begin
    rneg   = recent_i[RCPU_W-1];
    rmag   = rneg ? RCPU_W'(-recent_i) : RCPU_W'(recent_i);
    rx100  = (RX_W'(rmag) << 6) + (RX_W'(rmag) << 5) + (RX_W'(rmag) << 2);
    lx100  = (RX_W'(load_i) << 6) + (RX_W'(load_i) << 5) + (RX_W'(load_i) << 2);
    top_c  = PX_W'(PRI_TOP) <<< FRACTION_BITS;
    nice_c = PX_W'(nice_i) <<< (FRACTION_BITS + 1);
    q4_c   = signed'(PX_W'(rmag >> 2));
    px     = top_c - nice_c + (rneg ? q4_c : -q4_c);
  end

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      rneg_q <= rneg;
      idle_q <= idle_i;
      rx_q   <= rx100;
      lx_q   <= lx100;
      px_q   <= px;
    end
  end

  // Rounding stage
  always_comb begin
    rr          = ({1'b0, rx_q} + HALF_R) >> FRACTION_BITS;
    lr          = ({1'b0, lx_q} + HALF_R) >> FRACTION_BITS;
    pu          = (PX_W'(px_q) + HALF_P) >> FRACTION_BITS;
    rcpu_x100_o = RCPU_W'(rneg_q ? ((RX_W + 1)'(0) - rr) : rr);
    lavg_x100_o = LAVG_W'(lr);
    if (idle_q || px_q[PX_W-1]) begin
      prio_o = '0;
    end else if (pu > PX_W'(PRI_TOP)) begin
      prio_o = PRIO_W'(PRI_TOP);
    end else begin
      prio_o = PRIO_W'(pu);
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_mlfq_priority_update_engine.sv
// ----------------------------------------------------------------------------
// tb_mlfq_priority_update_engine
// Self-checking bench for the scheduler fixed-point engine. A directed table
// covers reset state, field extremes, saturation, idle words and spare
// function codes. Random words follow, aimed at a few busy threads. A local
// model of the load average and thread table predicts every result word that
// the table does not fix by hand. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mlfq_priority_update_engine
  import mlfq_pkg::*;
();

  localparam int THREAD_SLOTS  = 64;
  localparam int FRAC_BITS     = 14;
  localparam int CLK_PERIOD    = 10;
  localparam int RAND_ITEMS    = 1825;
  localparam int DIR_ROWS      = 25;
  // Slowest operation is decay (divide then multiply); leave margin.
  localparam int DRAIN_CYCLES  = 4 * FRAC_BITS + 40;
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  // Function codes the block treats as a query
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

  typedef struct packed {
    logic        [FUNC_W-1:0]  func;
    logic        [TIDX_W-1:0]  tidx;
    logic                      idle;
    logic signed [NICE_W-1:0]  nice;
    logic        [READY_W-1:0] ready;
  } sched_word_t;

  typedef struct packed {
    logic        [PRIO_W-1:0] prio;
    logic signed [RCPU_W-1:0] rcpu_x100;
    logic        [LAVG_W-1:0] lavg_x100;
    logic signed [NICE_W-1:0] nice;
  } sched_status_t;

  typedef struct packed {
    sched_word_t   w;
    logic          fixed_want;
    sched_status_t want;
  } stim_row_t;

  // Directed words. Rows with fixed_want set carry a hand-computed result;
  // the rest are checked against the thread model.
  localparam stim_row_t STIM_TABLE [DIR_ROWS] = '{
    // reset state: top priority, everything zero
    '{'{FN_QUERY, 6'd0, 1'b0, 6'sd0, 7'd0}, 1'b1, '{6'd63, 32'sd0, 13'd0, 6'sd0}},
    // nice 31 saturates to 20
    '{'{FN_NICE, 6'd63, 1'b0, 6'h1F, 7'd0}, 1'b1, '{6'd23, 32'sd0, 13'd0, 6'sd20}},
    // nice -32 saturates to -20; priority clamps at the top
    '{'{FN_NICE, 6'd1, 1'b0, 6'h20, 7'd0}, 1'b1, '{6'd63, 32'sd0, 13'd0, -6'sd20}},
    // idle set nice changes nothing, priority forced to 0
    '{'{FN_NICE, 6'd2, 1'b1, 6'sd5, 7'd0}, 1'b1, '{6'd0, 32'sd0, 13'd0, 6'sd0}},
    // decay with zero load: coefficient 0, recent becomes nice
    '{'{FN_DECAY, 6'd63, 1'b0, 6'sd0, 7'd0}, 1'b1, '{6'd18, 32'sd2000, 13'd0, 6'sd20}},
    '{'{FN_TICK, 6'd0, 1'b0, 6'sd0, 7'd0}, 1'b1, '{6'd63, 32'sd100, 13'd0, 6'sd0}},
    // idle tick changes nothing
    '{'{FN_TICK, 6'd0, 1'b1, 6'sd0, 7'd0}, 1'b1, '{6'd0, 32'sd100, 13'd0, 6'sd0}},
    // ready 127 saturates to 64
    '{'{FN_LOAD, 6'd0, 1'b0, 6'sd0, 7'd127}, 1'b1, '{6'd63, 32'sd100, 13'd107, 6'sd0}},
    // load update still runs on an idle word
    '{'{FN_LOAD, 6'd5, 1'b1, 6'sd0, 7'd64}, 1'b0, '0},
    '{'{FN_LOAD, 6'd5, 1'b0, 6'sd0, 7'd65}, 1'b0, '0},
    '{'{FN_DECAY, 6'd0, 1'b0, 6'sd0, 7'd0}, 1'b0, '0},
    // negative nice drives recent below zero
    '{'{FN_DECAY, 6'd1, 1'b0, 6'sd0, 7'd0}, 1'b0, '0},
    '{'{FN_DECAY, 6'd63, 1'b1, 6'sd0, 7'd0}, 1'b0, '0},
    '{'{FN_DECAY, 6'd63, 1'b0, 6'sd0, 7'd0}, 1'b0, '0},
    '{'{FN_TICK, 6'd1, 1'b0, 6'sd0, 7'd0}, 1'b0, '0},
    '{'{FN_NICE, 6'd3, 1'b0, 6'sd20, 7'd0}, 1'b0, '0},
    '{'{FN_NICE, 6'd4, 1'b0, -6'sd20, 7'd0}, 1'b0, '0},
    '{'{FN_NICE, 6'd63, 1'b0, 6'sd0, 7'd0}, 1'b0, '0},
    '{'{FN_NICE, 6'd6, 1'b0, 6'sd21, 7'd0}, 1'b0, '0},
    '{'{FN_NICE, 6'd7, 1'b0, -6'sd21, 7'd0}, 1'b0, '0},
    // spare function codes act as query
    '{'{FN_SPARE_A, 6'd0, 1'b0, 6'sd0, 7'd0}, 1'b0, '0},
    '{'{FN_SPARE_B, 6'd1, 1'b1, 6'sd0, 7'd0}, 1'b0, '0},
    '{'{FN_SPARE_C, 6'd63, 1'b0, 6'sd0, 7'd0}, 1'b0, '0},
    // largest raw nice and ready, which a query ignores; idle set
    '{'{FN_QUERY, 6'd62, 1'b1, 6'h1F, 7'h7F}, 1'b0, '0},
    '{'{FN_TICK, 6'd63, 1'b0, 6'sd0, 7'd0}, 1'b0, '0}
  };

  // Clock, reset and block inputs, all known from time zero
  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid_i     = 1'b0;
  logic        [FUNC_W-1:0]  func_i         = '0;
  logic        [TIDX_W-1:0]  thread_index_i = '0;
  logic                      is_idle_i      = 1'b0;
  logic signed [NICE_W-1:0]  nice_value_i   = '0;
  logic        [READY_W-1:0] ready_count_i  = '0;
  logic                      out_stall_i    = 1'b0;

  logic                      in_stall_o;
  logic                      out_valid_o;
  logic        [PRIO_W-1:0]  priority_res_o;
  logic signed [RCPU_W-1:0]  recent_cpu_x100_o;
  logic        [LAVG_W-1:0]  load_avg_x100_o;
  logic signed [NICE_W-1:0]  nice_out_o;

  // Thread model state
  logic        [LOAD_W-1:0]  load_avg_fp;
  logic signed [RCPU_W-1:0]  recent_fp [THREAD_SLOTS];
  logic signed [NICE_W-1:0]  nice_tbl  [THREAD_SLOTS];

  sched_status_t expected_status_q [$];
  sched_status_t oldest_status;
  int unsigned   mismatch_count = 0;
  int unsigned   burst_left     = 0;
  logic [11:0]   stall_cycle;
  int unsigned   stall_left;

  mlfq_priority_update_engine #(
    .THREAD_SLOTS  (THREAD_SLOTS),
    .FRACTION_BITS (FRAC_BITS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .thread_index_i    (thread_index_i),
    .is_idle_i         (is_idle_i),
    .nice_value_i      (nice_value_i),
    .ready_count_i     (ready_count_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .priority_res_o    (priority_res_o),
    .recent_cpu_x100_o (recent_cpu_x100_o),
    .load_avg_x100_o   (load_avg_x100_o),
    .nice_out_o        (nice_out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Round to nearest, ties away from zero, dropping the fraction bits.
  function automatic longint round_fixed(input longint x, input longint one);
    if (x >= 0) return (x + one / 2) / one;
    return (x - one / 2) / one;
  endfunction

  // Apply one word to the thread model and return the status it reports.
  function automatic sched_status_t apply_sched_op(input sched_word_t w);
    longint        one, recent, nice, load, rdy, nv, twol, coef, pri, acc;
    int unsigned   slot;
    sched_status_t st;
    one  = longint'(1) << FRAC_BITS;
    slot = w.tidx % THREAD_SLOTS;
    rdy  = (w.ready > READY_MAX) ? READY_MAX : longint'(w.ready);
    nv   = longint'(w.nice);
    if (nv > NICE_HI) nv = NICE_HI;
    if (nv < NICE_LO) nv = NICE_LO;
    recent = longint'(recent_fp[slot]);
    nice   = longint'(nice_tbl[slot]);
    load   = longint'(load_avg_fp);

    // Load update ignores the idle flag: the ready count already excludes it.
    if (w.func == FN_LOAD) begin
      acc = (((59 * one) / 60) * load) / one + (one / 60) * rdy;
      load_avg_fp = LOAD_W'(acc);
    end else if (!w.idle) begin
      case (w.func)
        FN_TICK: recent_fp[slot] = RCPU_W'(recent + one);
        FN_DECAY: begin
          twol = 2 * load;
          coef = (twol * one) / (twol + one);
          recent_fp[slot] = RCPU_W'((coef * recent) / one + nice * one);
        end
        FN_NICE: nice_tbl[slot] = NICE_W'(nv);
        default: ;
      endcase
    end

    recent = longint'(recent_fp[slot]);
    nice   = longint'(nice_tbl[slot]);
    load   = longint'(load_avg_fp);
    pri = round_fixed(PRI_TOP * one - recent / 4 - 2 * nice * one, one);
    if (pri < 0) pri = 0;
    if (pri > PRI_TOP) pri = PRI_TOP;
    if (w.idle) pri = 0;

    st.prio      = PRIO_W'(pri);
    st.rcpu_x100 = RCPU_W'(round_fixed(recent * 100, one));
    st.lavg_x100 = LAVG_W'(round_fixed(load * 100, one));
    st.nice      = nice_tbl[slot];
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t ERROR: %s", $time, msg);
  endtask

  // Offer one word. Open a new burst with a random gap when the last one is
  // spent; hold the payload until the block takes it, then queue its result.
  task automatic drive_word(input sched_word_t w, input logic fixed_want,
                            input sched_status_t want);
    int unsigned   gap;
    sched_status_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    func_i         <= w.func;
    thread_index_i <= w.tidx;
    is_idle_i      <= w.idle;
    nice_value_i   <= w.nice;
    ready_count_i  <= w.ready;
    do @(posedge clk_i); while (in_stall_o);
    // Run the model on every word so its state tracks the block.
    pred = apply_sched_op(w);
    expected_status_q.push_back(fixed_want ? want : pred);
  endtask

  // Receiver: stall in random runs, with calm stretches of no stall at all.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cycle <= '0;
      stall_left  <= 0;
    end else begin
      stall_cycle <= stall_cycle + 1'b1;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left  <= ($urandom_range(0, 7) == 0) ? $urandom_range(16, 30)
                                                   : $urandom_range(0, 6);
        out_stall_i <= (stall_cycle[11:10] != 2'b11) && ($urandom_range(0, 1) == 1);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("result word with no expectation pending");
      end else begin
        oldest_status = expected_status_q.pop_front();
        if (priority_res_o !== oldest_status.prio)
          report_mismatch($sformatf("priority_res got %0d want %0d",
                                    priority_res_o, oldest_status.prio));
        if (recent_cpu_x100_o !== oldest_status.rcpu_x100)
          report_mismatch($sformatf("recent_cpu_x100 got %0d want %0d",
                                    recent_cpu_x100_o, oldest_status.rcpu_x100));
        if (load_avg_x100_o !== oldest_status.lavg_x100)
          report_mismatch($sformatf("load_avg_x100 got %0d want %0d",
                                    load_avg_x100_o, oldest_status.lavg_x100));
        if (nice_out_o !== oldest_status.nice)
          report_mismatch($sformatf("nice_out got %0d want %0d",
                                    nice_out_o, oldest_status.nice));
      end
    end
  end

  // Main sequence: reset, directed table, random words, drain.
  initial begin
    sched_word_t w;
    int unsigned roll;
    load_avg_fp = '0;
    for (int i = 0; i < THREAD_SLOTS; i++) begin
      recent_fp[i] = '0;
      nice_tbl[i]  = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block stalls input through its table clearing pass; the
    // handshake wait absorbs it.
    for (int i = 0; i < DIR_ROWS; i++)
      drive_word(STIM_TABLE[i].w, STIM_TABLE[i].fixed_want, STIM_TABLE[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Halfway, hold off until every outstanding result is back.
      if (n == RAND_ITEMS / 2) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_status_q.size() != 0);
      end
      // Ticks most often, mostly on a few hot threads so recent cpu builds up,
      // interleaved with load updates, decays, nice changes and queries.
      roll = $urandom_range(0, 99);
      if (roll < 35)      w.func = FN_TICK;
      else if (roll < 50) w.func = FN_LOAD;
      else if (roll < 65) w.func = FN_DECAY;
      else if (roll < 80) w.func = FN_NICE;
      else if (roll < 95) w.func = FN_QUERY;
      else                w.func = FUNC_W'($urandom_range(FN_SPARE_A, FN_SPARE_C));
      w.tidx  = ($urandom_range(0, 3) != 0) ? TIDX_W'($urandom_range(0, 7))
                                            : TIDX_W'($urandom_range(0, THREAD_SLOTS - 1));
      w.idle  = ($urandom_range(0, 9) == 0);
      w.nice  = ($urandom_range(0, 6) != 0) ? NICE_W'($urandom_range(0, 40) - 20)
                                            : NICE_W'($urandom);
      w.ready = ($urandom_range(0, 6) != 0) ? READY_W'($urandom_range(0, READY_MAX))
                                            : READY_W'($urandom_range(READY_MAX + 1, 127));
      drive_word(w, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    // Let any stray extra result word surface before closing.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mlfq_pkg.sv
rtl/mlfq_muldiv.sv
rtl/mlfq_table.sv
rtl/mlfq_fmt.sv
rtl/mlfq_priority_update_engine.sv
test/tb_mlfq_priority_update_engine.sv
